>>> rtl/core/mmul_pkg.sv
`timescale 1ns / 1ps

package mmul_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_DIM_DEFAULT   = 8;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Fixed field widths of the channels.
   localparam int OP_W     = 2;
   localparam int IDX_W    = 3;
   localparam int VAL_W    = 32;
   localparam int CFG_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int REQ_PAD_W  = REQ_DATA_W - 2 * IDX_W - VAL_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * IDX_W - VAL_W;

   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(4);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2,
      REG_UNUSED    = 2'd3
   } csr_index_type;

   // Travels with each store read through the multiply-accumulate pipeline.
   typedef struct packed {
      logic             first;
      logic             last_k;
      logic             last_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   typedef struct packed {
      logic    wr_a;
      logic    wr_b;
      logic    rd_valid;
      tag_type tag;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic res_done;
   } status_type;

endpackage

>>> rtl/core/mmul_ram.sv
`timescale 1ns / 1ps

module mmul_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mmul_ctrl.sv
`timescale 1ns / 1ps

module mmul_ctrl #(
   parameter int MAX_DIM = 8,
   localparam int ADDR_W = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mmul_pkg::OP_W-1:0]       req_op,
   input  logic                            csr_we,
   input  logic [mmul_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mmul_pkg::CFG_W-1:0]      csr_wdata,
   input  mmul_pkg::status_type            status,
   output mmul_pkg::cmd_type               cmd,
   output logic [ADDR_W-1:0]               a_rd_addr,
   output logic [ADDR_W-1:0]               b_rd_addr
);

   import mmul_pkg::*;

   localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_ISSUE = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DIM_W-1:0] nr_m1, nk_m1, nc_m1;
   logic             req_accept;
   logic             at_last_elem;

   // A size of zero counts as one, and anything beyond the store as the store size.
   function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
      int n;
      n = int'(v);
      if (n == 0) begin
         n = 1;
      end
      if (n > MAX_DIM) begin
         n = MAX_DIM;
      end
      return DIM_W'(n - 1);
   endfunction

   assign nr_m1 = dim_last(rows_a_ff);
   assign nk_m1 = dim_last(inner_dim_ff);
   assign nc_m1 = dim_last(cols_b_ff);

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign at_last_elem = (i_ff == nr_m1) && (j_ff == nc_m1);

   assign a_rd_addr = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign b_rd_addr = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (op_type'(req_op))
                  OP_LOAD_A: begin
                     cmd.wr_a = 1'b1;
                  end
                  OP_LOAD_B: begin
                     cmd.wr_b = 1'b1;
                  end
                  OP_COMPUTE: begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_START;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_START: begin
            // Only one element is in flight, so a free output register now
            // stays free until its sum arrives.
            if (status.out_free) begin
               k_in     = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.rd_valid      = 1'b1;
            cmd.tag.first     = (k_ff == '0);
            cmd.tag.last_k    = (k_ff == nk_m1);
            cmd.tag.last_elem = at_last_elem;
            cmd.tag.row       = IDX_W'(i_ff);
            cmd.tag.col       = IDX_W'(j_ff);
            if (k_ff == nk_m1) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.res_done) begin
               if (at_last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_START;
                  if (j_ff == nc_m1) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_ROWS_A:    rows_a_ff    <= csr_wdata;
               REG_INNER_DIM: inner_dim_ff <= csr_wdata;
               REG_COLS_B:    cols_b_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

`ifndef NO_ASSERTIONS
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      status.res_done |-> state_ff == ST_DRAIN)
      else $error("result finished outside the drain state");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (status.res_done && at_last_elem) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after the last element");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_valid |-> k_ff <= nk_m1)
      else $error("inner index ran past the inner dimension");
`endif

endmodule

>>> rtl/core/mmul_datapath.sv
`timescale 1ns / 1ps

module mmul_datapath #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16,
   localparam int ADDR_W = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mmul_pkg::IDX_W-1:0]  req_row,
   input  logic [mmul_pkg::IDX_W-1:0]  req_col,
   input  logic [mmul_pkg::VAL_W-1:0]  req_value,
   input  mmul_pkg::cmd_type           cmd,
   input  logic [ADDR_W-1:0]           a_rd_addr,
   input  logic [ADDR_W-1:0]           b_rd_addr,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [mmul_pkg::IDX_W-1:0]  rsp_row,
   output logic [mmul_pkg::IDX_W-1:0]  rsp_col,
   output logic [mmul_pkg::VAL_W-1:0]  rsp_value,
   output logic                        rsp_sat,
   output logic                        rsp_last,
   output mmul_pkg::status_type        status
);

   import mmul_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int CNT_W = $clog2(MAX_DIM + 1);
   // Room for the exact sum of up to MAX_DIM full-precision products.
   localparam int ACC_W = 2 * VAL_W + CNT_W;

   logic              ld_ok;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  a_rd, b_rd;
   logic signed [VAL_W-1:0]   a_val, b_val;
   logic signed [2*VAL_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in, shifted;
   logic [ACC_W-VAL_W:0]      hi_bits;
   logic              overflow;

   logic    s1_valid_ff, s2_valid_ff, fin_valid_ff;
   tag_type s1_tag_ff, s2_tag_ff, fin_tag_ff;

   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [IDX_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_sat_ff, rsp_last_ff;

   // A load beyond the store is dropped.
   assign ld_ok   = (int'(req_row) < MAX_DIM) && (int'(req_col) < MAX_DIM);
   assign wr_addr = ADDR_W'(int'(req_row) * MAX_DIM + int'(req_col));

   mmul_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (cmd.wr_a && ld_ok),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd)
   );

   mmul_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_b_store (
      .clock   (clock),
      .wr_en   (cmd.wr_b && ld_ok),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   assign a_val   = a_rd;
   assign b_val   = b_rd;
   assign prod_in = (2*VAL_W)'(a_val) * (2*VAL_W)'(b_val);
   assign acc_in  = s2_tag_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   // Floor shift back to the result format, then clip to the 32-bit range.
   assign shifted  = acc_ff >>> FRAC_BITS;
   assign hi_bits  = shifted[ACC_W-1:VAL_W-1];
   assign overflow = !(&hi_bits) && (|hi_bits);
   assign rsp_value_in = overflow ? (shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                     : {1'b0, {(VAL_W-1){1'b1}}})
                                  : shifted[VAL_W-1:0];

   assign status.out_free = !rsp_tvalid_ff || rsp_tready;
   assign status.res_done = fin_valid_ff;

   always_comb begin
      if (fin_valid_ff) begin
         rsp_tvalid_in = 1'b1;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         fin_valid_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= cmd.rd_valid;
         s2_valid_ff   <= s1_valid_ff;
         fin_valid_ff  <= s2_valid_ff && s2_tag_ff.last_k;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= cmd.tag;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= prod_in;
      if (s2_valid_ff) begin
         acc_ff     <= acc_in;
         fin_tag_ff <= s2_tag_ff;
      end
      if (fin_valid_ff) begin
         rsp_row_ff   <= fin_tag_ff.row;
         rsp_col_ff   <= fin_tag_ff.col;
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff   <= overflow;
         rsp_last_ff  <= fin_tag_ff.last_elem;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_sat    = rsp_sat_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff |-> status.out_free)
      else $error("finished sum would overwrite a result still waiting");
`endif

endmodule

>>> rtl/core/matrix_multiply.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload
// req      in         tuser: op; tdata: row_index, col_index, value
// rsp      out        tuser: saturated; tlast: last; tdata: out_row, out_col, out_value
// csr      in         write enable, register index, write data
//
// Load items are taken one per cycle. A compute item holds req_tready low while the
// single multiply-accumulate walks both stores, one product per cycle; each result
// element starts only once its predecessor has left the output register on rsp.
// Reset is synchronous and clears control state and the size registers; the stores
// are not cleared. A stalled rsp holds the next element at its start.

module matrix_multiply #(
   parameter int MAX_DIM   = mmul_pkg::MAX_DIM_DEFAULT,
   parameter int FRAC_BITS = mmul_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // op
   input  logic [mmul_pkg::OP_W-1:0]            req_tuser,
   // row_index, col_index, value, zero padding
   input  logic [mmul_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tlast,
   // saturated
   output logic                                 rsp_tuser,
   // out_row, out_col, out_value, zero padding
   output logic [mmul_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [mmul_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mmul_pkg::CFG_W-1:0]           csr_wdata
);

   import mmul_pkg::*;

   localparam int ADDR_W = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

   cmd_type           cmd;
   status_type        status;
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   logic [IDX_W-1:0]  rsp_row, rsp_col;
   logic [VAL_W-1:0]  rsp_value;

   mmul_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cmd        (cmd),
      .a_rd_addr  (a_rd_addr),
      .b_rd_addr  (b_rd_addr)
   );

   mmul_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_row    (req_tdata[IDX_W-1:0]),
      .req_col    (req_tdata[2*IDX_W-1:IDX_W]),
      .req_value  (req_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
      .cmd        (cmd),
      .a_rd_addr  (a_rd_addr),
      .b_rd_addr  (b_rd_addr),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_value  (rsp_value),
      .rsp_sat    (rsp_tuser),
      .rsp_last   (rsp_tlast),
      .status     (status)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_value, rsp_col, rsp_row};

endmodule

>>> tb/matrix_multiply_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_tb;
   import mmul_pkg::*;

   localparam int DIM  = MAX_DIM_DEFAULT;
   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam longint Q_MAX = 64'sh7FFF_FFFF;
   localparam longint Q_MIN = -64'sh8000_0000;
   // Quiet time after the last element of C has come back; leave a wide margin.
   localparam int SETTLE_CYCLES = 32;

   typedef struct {
      op_type            op;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [VAL_W-1:0]  value;
   } request_t;

   typedef struct {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [VAL_W-1:0]  value;
      logic              sat;
      logic              last;
   } element_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // op
   logic [OP_W-1:0]         req_tuser = '0;
   // row_index, col_index, value, zero padding
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    rsp_tlast;
   // saturated
   logic                    rsp_tuser;
   // out_row, out_col, out_value, zero padding
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   matrix_multiply u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Our copy of the block: element stores and size registers.
   logic [VAL_W-1:0] model_a [DIM*DIM] = '{default: '0};
   logic [VAL_W-1:0] model_b [DIM*DIM] = '{default: '0};
   logic [CFG_W-1:0] size_rows  = DIM_RESET;
   logic [CFG_W-1:0] size_inner = DIM_RESET;
   logic [CFG_W-1:0] size_cols  = DIM_RESET;

   // Elements already loaded, as seen by the stimulus generator.
   bit a_seen [DIM*DIM];
   bit b_seen [DIM*DIM];

   request_t pending_items [$];
   element_t expected_elems [$];
   request_t on_bus;

   int idle_pct  = 0;
   int gap_left  = 0;
   int stall_left = 0;
   int items_queued = 0;
   int mismatches = 0;
   int load_count = 0;
   int product_count = 0;
   int noise_count = 0;
   int element_count = 0;
   int sat_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("matrix_multiply test failed");
      $finish;
   end

   function automatic int eff_dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return int'(v);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at %0t: element %0d %s got 0x%0h expected 0x%0h",
               $realtime, element_count, what, got, want);
      mismatches++;
   endtask

   // Applies one accepted item to our copy and queues the elements of C it causes.
   function automatic void apply_request(request_t it);
      int nr, nk, nc, i, j, k;
      longint prod;
      logic signed [127:0] acc;
      logic signed [127:0] shifted;
      element_t e;
      case (it.op)
         OP_LOAD_A: begin
            model_a[{it.row, it.col}] = it.value;
            load_count++;
         end
         OP_LOAD_B: begin
            model_b[{it.row, it.col}] = it.value;
            load_count++;
         end
         OP_COMPUTE: begin
            product_count++;
            nr = eff_dim(size_rows);
            nk = eff_dim(size_inner);
            nc = eff_dim(size_cols);
            for (i = 0; i < nr; i++) begin
               for (j = 0; j < nc; j++) begin
                  acc = '0;
                  for (k = 0; k < nk; k++) begin
                     prod = longint'($signed(model_a[i*DIM+k])) *
                            longint'($signed(model_b[k*DIM+j]));
                     acc = acc + prod;
                  end
                  // Arithmetic shift of a signed sum rounds toward minus infinity.
                  shifted = acc >>> FRAC;
                  e.row  = IDX_W'(i);
                  e.col  = IDX_W'(j);
                  e.last = (i == nr - 1) && (j == nc - 1);
                  if (shifted > Q_MAX) begin
                     e.value = 32'h7FFF_FFFF;
                     e.sat   = 1'b1;
                  end else if (shifted < Q_MIN) begin
                     e.value = 32'h8000_0000;
                     e.sat   = 1'b1;
                  end else begin
                     e.value = shifted[VAL_W-1:0];
                     e.sat   = 1'b0;
                  end
                  expected_elems.push_back(e);
               end
            end
         end
         default: noise_count++;
      endcase
   endfunction

   task automatic check_element();
      element_t want;
      logic [IDX_W-1:0] got_row, got_col;
      logic [VAL_W-1:0] got_value;
      got_row   = rsp_tdata[IDX_W-1:0];
      got_col   = rsp_tdata[2*IDX_W-1:IDX_W];
      got_value = rsp_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
      if (expected_elems.size() == 0) begin
         report_mismatch("unexpected element, value", got_value, 0);
      end else begin
         want = expected_elems.pop_front();
         if (got_row !== want.row) report_mismatch("row", got_row, want.row);
         if (got_col !== want.col) report_mismatch("col", got_col, want.col);
         if (got_value !== want.value) report_mismatch("value", got_value, want.value);
         if (rsp_tuser !== want.sat) report_mismatch("saturated", rsp_tuser, want.sat);
         if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
         if (want.sat) sat_count++;
      end
      element_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0 && idle_pct != 0 &&
                         $urandom_range(0, 99) < idle_pct) begin
               gap_left = $urandom_range(0, 12);
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               on_bus = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.op;
               req_tdata  <= {{REQ_PAD_W{1'b0}}, on_bus.value, on_bus.col, on_bus.row};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_element();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic void queue_item(op_type op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                      logic [VAL_W-1:0] v);
      request_t it;
      it.op    = op;
      it.row   = r;
      it.col   = c;
      it.value = v;
      pending_items.push_back(it);
      items_queued++;
      if (op == OP_LOAD_A) a_seen[{r, c}] = 1'b1;
      if (op == OP_LOAD_B) b_seen[{r, c}] = 1'b1;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 6))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return VAL_W'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
         3: return VAL_W'($urandom_range(0, 2)) - 32'd1;
         4: return {$urandom_range(0, 1) ? 8'h7F : 8'h80, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_index(int lim);
      if ($urandom_range(0, 99) < 80) return IDX_W'($urandom_range(0, lim - 1));
      return IDX_W'($urandom_range(0, DIM - 1));
   endfunction

   function automatic logic [CFG_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return CFG_W'($urandom_range(1, 4));
      if (roll < 80) return CFG_W'($urandom_range(5, DIM));
      if (roll < 93) return CFG_W'($urandom_range(DIM + 1, 15));
      return '0;
   endfunction

   // A compute must never read an element that was not loaded, so any gap in the
   // operands is filled first.
   function automatic void queue_compute();
      int nr, nk, nc, i, j;
      nr = eff_dim(size_rows);
      nk = eff_dim(size_inner);
      nc = eff_dim(size_cols);
      for (i = 0; i < nr; i++)
         for (j = 0; j < nk; j++)
            if (!a_seen[i*DIM+j]) queue_item(OP_LOAD_A, IDX_W'(i), IDX_W'(j), pick_value());
      for (i = 0; i < nk; i++)
         for (j = 0; j < nc; j++)
            if (!b_seen[i*DIM+j]) queue_item(OP_LOAD_B, IDX_W'(i), IDX_W'(j), pick_value());
      queue_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
   endfunction

   task automatic write_csr(csr_index_type idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_ROWS_A:    size_rows  = val;
         REG_INNER_DIM: size_inner = val;
         REG_COLS_B:    size_cols  = val;
         default: ;
      endcase
   endtask

   task automatic set_sizes(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
      write_csr(REG_ROWS_A, r);
      write_csr(REG_INNER_DIM, k);
      write_csr(REG_COLS_B, c);
      if ($urandom_range(0, 3) == 0) write_csr(REG_UNUSED, CFG_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every item is taken and every element of C has come back.
   task automatic settle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_elems.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int n, i;
      op_type op;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Directed: single-element products at the value extremes.
      idle_pct = 25;
      set_sizes(4'd1, 4'd1, 4'd1);
      write_csr(REG_UNUSED, 4'hF);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      queue_item(OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
      queue_item(OP_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
      queue_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
      queue_item(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
      queue_item(OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
      queue_item(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
      queue_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
      // 1.5 times a small negative value: the shift must round downwards.
      queue_item(OP_LOAD_A, 3'd0, 3'd0, 32'h0001_8000);
      queue_item(OP_LOAD_B, 3'd0, 3'd0, 32'hFFFF_0001);
      queue_item(OP_NONE, 3'd7, 3'd7, 32'hFFFF_FFFF);
      queue_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
      // Elements outside the present size are kept for a later, larger setting.
      queue_item(OP_LOAD_A, 3'd0, 3'd7, 32'h7FFF_FFFF);
      queue_item(OP_LOAD_B, 3'd7, 3'd0, 32'h7FFF_FFFF);
      queue_item(OP_NONE, 3'd0, 3'd0, 32'h0);
      settle();

      // Zero is taken as one and fifteen as the full size.
      set_sizes(4'd0, 4'd15, 4'd0);
      queue_compute();
      settle();

      // Fill both stores completely at the full size, then random phases.
      set_sizes(4'd8, 4'd9, 4'd8);
      queue_compute();
      while (items_queued < 250) begin
         settle();
         idle_pct = (items_queued > 210) ? 0 : (($urandom_range(0, 2) == 0) ? 0 :
                    ($urandom_range(0, 1) ? 15 : 50));
         set_sizes(pick_size(), pick_size(), pick_size());
         n = $urandom_range(0, 10);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_item(OP_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end else begin
               op = $urandom_range(0, 1) ? OP_LOAD_A : OP_LOAD_B;
               if (op == OP_LOAD_A)
                  queue_item(op, pick_index(eff_dim(size_rows)),
                             pick_index(eff_dim(size_inner)), pick_value());
               else
                  queue_item(op, pick_index(eff_dim(size_inner)),
                             pick_index(eff_dim(size_cols)), pick_value());
            end
         end
         queue_compute();
         if ($urandom_range(0, 4) == 0) queue_compute();
      end
      settle();

      $display("Ran %0d loads, %0d products and %0d ignored items over many size settings;",
               load_count, product_count, noise_count);
      $display("%0d result elements checked, %0d of them clipped.", element_count, sat_count);
      if (mismatches == 0) begin
         $display("matrix_multiply test passed");
      end else begin
         $display("matrix_multiply test failed");
      end
      $finish;
   end

endmodule

>>> matrix_multiply.f
rtl/core/mmul_pkg.sv
rtl/core/mmul_ram.sv
rtl/core/mmul_ctrl.sv
rtl/core/mmul_datapath.sv
rtl/core/matrix_multiply.sv
tb/matrix_multiply_tb.sv
